### rtl/core/pnds_pkg.sv
// Shared types and constants for the pink noise dice-sum core.
`default_nettype none

package pnds_pkg;

    // Width of one raw random word and of the output sample
    localparam int WORD_W = 32;
    // Raw words are used shifted right by this many bits
    localparam int RAND_SHIFT = 4;
    // Width of one die value
    localparam int DIE_W = WORD_W - RAND_SHIFT;
    // Width of the quantize control register
    localparam int QBITS_W = 5;

    typedef logic [DIE_W-1:0]   die_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [QBITS_W-1:0] qbits_t;

    // Payload handed from the dice bank to the output stage
    typedef struct packed {
        word_t total;
        die_t  white;
    } mid_t;

endpackage

`default_nettype wire

### rtl/core/pink_noise_dice_sum_core.sv
// Top level of the Voss-McCartney pink noise dice-sum core.
//
//  Port group      Dir  Handshake                      Contents
//  s_axis_*        in   tvalid/tready                  two raw random words
//  m_axis_*        out  tvalid/tready                  pink noise sample
//  cfg_wr_*        in   write enable, no wait          quantize_bits
//
// One transaction per clock is sustained while m_axis_tready stays high; the die swap
// and total update sit between the input and mid registers, followed by the sum/quantize stage.
// A sample passes through the input, mid and output registers in that order.
// Reset clears all dice, the running total, the step counter and quantize_bits.
// Stalls on m_axis back up through the stage registers to s_axis_tready.
`default_nettype none

module pink_noise_dice_sum_core #(
    parameter int NUM_DICE = 15
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] rand_first, [63:32] rand_second
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] noise_sample
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data     // [4:0] quantize_bits
);
    import pnds_pkg::*;

    qbits_t qbits_reg;
    logic   in_valid_reg;
    die_t   first_reg;
    die_t   second_reg;
    logic   bank_ready;
    logic   mid_valid;
    logic   mid_ready;
    mid_t   mid;
    word_t  out_data;

    // Write the quantize register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qbits_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            qbits_reg <= cfg_wr_data;
        end
    end

    assign s_axis_tready = !in_valid_reg || bank_ready;

    // Hold the input valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Capture both words, dropping their low bits
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            first_reg  <= s_axis_tdata[WORD_W-1:RAND_SHIFT];
            second_reg <= s_axis_tdata[2*WORD_W-1:WORD_W+RAND_SHIFT];
        end
    end

    pnds_dice_bank #(
        .NUM_DICE (NUM_DICE)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (bank_ready),
        .first     (first_reg),
        .second    (second_reg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid)
    );

    pnds_quant_out u_quant (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .qbits     (qbits_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data;

endmodule

`default_nettype wire

### rtl/core/pnds_dice_bank.sv
// Dice store, running total and step counter; at most one die update per transaction.
`default_nettype none

module pnds_dice_bank #(
    parameter int NUM_DICE = 15
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pnds_pkg::die_t first,
    input  wire pnds_pkg::die_t second,
    output logic               mid_valid,
    input  wire logic          mid_ready,
    output pnds_pkg::mid_t     mid
);
    import pnds_pkg::*;

    localparam int IDX_W = (NUM_DICE > 1) ? $clog2(NUM_DICE) : 1;

    die_t                 dice_reg [NUM_DICE];
    word_t                total_reg;
    word_t                total_next;
    logic [NUM_DICE-1:0]  count_reg;
    logic                 mid_valid_reg;
    mid_t                 mid_reg;
    mid_t                 mid_next;
    logic [IDX_W-1:0]     idx;
    logic                 count_nz;
    logic                 accept;

    // Accept when the mid register is empty or drains this cycle
    assign in_ready  = !mid_valid_reg || mid_ready;
    assign accept    = in_valid && in_ready;
    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

    // Find the lowest set bit of the step counter
    always_comb
    begin
        idx = '0;
        for (int i = NUM_DICE - 1; i >= 0; i--)
        begin
            if (count_reg[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

    assign count_nz = |count_reg;

    // Swap the chosen die into the total; pick the white term
    always_comb
    begin
        if (count_nz)
        begin
            total_next     = total_reg - WORD_W'(dice_reg[idx]) + WORD_W'(first);
            mid_next.white = second;
        end
        else
        begin
            total_next     = total_reg;
            mid_next.white = first;
        end
        mid_next.total = total_next;
    end

    // Update state on each transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DICE; i++)
            begin
                dice_reg[i] <= '0;
            end
            total_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (count_nz)
            begin
                dice_reg[idx] <= first;
            end
            total_reg <= total_next;
            count_reg <= count_reg + NUM_DICE'(1);
        end
    end

    // Hold the valid flag for the mid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            mid_valid_reg <= in_valid;
        end
    end

    // Capture the snapshot of total and white
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_reg <= mid_next;
        end
    end

    // Counter advances by one on every transaction
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> count_reg == $past(count_reg) + NUM_DICE'(1))
        else $error("step counter did not advance");

    // Total only moves on a transaction
    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(total_reg))
        else $error("running total changed without a transaction");

    // Snapshot matches the new total
    a_mid_total: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> mid_valid_reg && mid_reg.total == total_reg)
        else $error("mid snapshot out of step with total");

    // Total left alone when the counter is zero
    a_zero_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !count_nz |=> $stable(total_reg))
        else $error("total changed on a zero count");

endmodule

`default_nettype wire

### rtl/core/pnds_quant_out.sv
// Final sum, optional quantization and output register.
`default_nettype none

module pnds_quant_out (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             mid_valid,
    output logic                  mid_ready,
    input  wire pnds_pkg::mid_t   mid,
    input  wire pnds_pkg::qbits_t qbits,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pnds_pkg::word_t       out_data
);
    import pnds_pkg::*;

    logic  out_valid_reg;
    word_t out_data_reg;
    word_t out_data_next;
    word_t sum;
    word_t mask;

    assign mid_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Add white term, clear low bits and add back half the cleared range
    always_comb
    begin
        sum           = mid.total + WORD_W'(mid.white);
        mask          = {WORD_W{1'b1}} << qbits;
        out_data_next = (sum & mask) + ((~mask) >> 1);
    end

    // Hold the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            out_valid_reg <= mid_valid;
        end
    end

    // Capture the sample
    always_ff @(posedge clk)
    begin
        if (mid_valid && mid_ready)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

### bench/tb_pink_noise_dice_sum_core.sv
// Self-checking testbench for the pink noise dice-sum core.
`timescale 1ns / 1ps

module tb_pink_noise_dice_sum_core;

    import pnds_pkg::*;

    localparam int DICE = 15;

    // Predicts noise samples and checks the ones the core delivers
    class pink_sample_board;
        die_t              dice [DICE];
        word_t             dice_sum;
        logic [DICE-1:0]   step;
        qbits_t            qbits;
        word_t             sample_q [$];
        int                errors;

        function new();
            foreach (dice[i])
                dice[i] = '0;
            dice_sum = '0;
            step = '0;
            qbits = '0;
            errors = 0;
        endfunction

        function void set_qbits(qbits_t v);
            qbits = v;
        endfunction

        function int pending();
            return sample_q.size();
        endfunction

        // Swap one die, advance the counter and form the quantized sample
        function word_t next_sample(word_t first_raw, word_t second_raw);
            die_t  first_die;
            die_t  second_die;
            word_t white;
            word_t s;
            word_t keep;
            int    k;
            first_die = die_t'(first_raw >> RAND_SHIFT);
            second_die = die_t'(second_raw >> RAND_SHIFT);
            if (step != '0)
            begin
                k = 0;
                while (!step[k])
                    k++;
                dice_sum = dice_sum - word_t'(dice[k]) + word_t'(first_die);
                dice[k] = first_die;
                white = word_t'(second_die);
            end
            else
            begin
                white = word_t'(first_die);
            end
            step = step + DICE'(1);
            s = dice_sum + white;
            if (qbits != '0)
            begin
                keep = {WORD_W{1'b1}} << qbits;
                s = (s & keep) + (~keep >> 1);
            end
            return s;
        endfunction

        function void take_words(logic [63:0] words);
            sample_q.push_back(next_sample(words[31:0], words[63:32]));
        endfunction

        function void check_sample(word_t got);
            word_t want;
            if (sample_q.size() == 0)
            begin
                $display("%0t: unexpected noise_sample: expected nothing, got %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = sample_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: noise_sample mismatch: expected %h, got %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [63:0]  s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    word_t        m_data;
    logic         cfg_en = 1'b0;
    qbits_t       cfg_data = '0;

    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;
    logic         sink_hold = 1'b0;

    pink_sample_board board = new();

    pink_noise_dice_sum_core #(
        .NUM_DICE (DICE)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .cfg_wr_en     (cfg_en),
        .cfg_wr_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Drive the output ready: long hold-off or random stalls
    always @(negedge clk)
    begin
        if (sink_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_valid && m_ready)
                board.check_sample(m_data);
            if (s_valid && s_ready)
                board.take_words(s_data);
        end
    end

    // Offer one input transaction and return at the falling edge after it is taken
    task automatic push_words(word_t first, word_t second);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data <= {second, first};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random word biased toward the edges of the range
    function automatic word_t rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return word_t'($urandom_range(15));
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic push_random(int count);
        repeat (count)
            push_words(rand_word(), rand_word());
    endtask

    // Hold the sender until every sample is out
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    // Write quantize_bits while the core is idle
    task automatic write_qbits(qbits_t v);
        drain();
        repeat (4)
            @(negedge clk);
        cfg_en <= 1'b1;
        cfg_data <= v;
        board.set_qbits(v);
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    initial
    begin
        #(4_000_000);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: counter at zero first, then field extremes
        write_qbits(5'd0);
        push_words(32'hFFFF_FFFF, 32'h0000_0000);
        push_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_words(32'h0000_0000, 32'h0000_0000);
        push_words(32'h0000_000F, 32'h0000_000F);
        push_words(32'hAAAA_AAAA, 32'h5555_5555);
        push_words(32'h5555_5555, 32'hAAAA_AAAA);
        push_words(32'h0000_0010, 32'hFFFF_FFF0);
        push_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_words(32'h8000_0000, 32'h7FFF_FFFF);
        push_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Quantize at maximum and at the smallest nonzero setting
        write_qbits(5'd31);
        push_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_words(32'hFFFF_FFFF, 32'h0000_0000);
        push_words(32'h0000_0000, 32'hFFFF_FFFF);
        push_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_qbits(5'd1);
        push_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_words(32'h0000_0010, 32'h0000_0010);
        push_words(32'h1234_5678, 32'h9ABC_DEF0);
        push_words(32'h0000_0000, 32'h0000_0000);

        // Phase: no idling
        write_qbits(5'd0);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        push_random(250);

        // Phase: sender idles, with one pause until the pipe is empty
        write_qbits(qbits_t'($urandom_range(2, 30)));
        src_idle_pct = 70;
        sink_stall_pct = 0;
        push_random(120);
        drain();
        push_random(130);

        // Phase: receiver stalls, with one long hold-off to back up the input
        write_qbits(5'd31);
        src_idle_pct = 0;
        sink_stall_pct = 70;
        push_random(100);
        fork
            begin
                sink_hold = 1'b1;
                repeat (300)
                    @(posedge clk);
                sink_hold = 1'b0;
            end
            push_random(60);
        join
        push_random(90);

        // Bias the first word toward all ones to push the total toward wrap
        write_qbits(qbits_t'($urandom_range(1, 31)));
        src_idle_pct = 0;
        sink_stall_pct = 10;
        repeat (30)
            push_words(($urandom_range(1) != 0) ? 32'hFFFF_FFFF : rand_word(), rand_word());

        // Phase: both sides idle
        write_qbits(qbits_t'($urandom_range(0, 31)));
        src_idle_pct = 26;
        sink_stall_pct = 26;
        push_random(250);

        drain();
        repeat (8)
            @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### pink_noise_dice_sum_core.f
rtl/core/pnds_pkg.sv
rtl/core/pnds_dice_bank.sv
rtl/core/pnds_quant_out.sv
rtl/core/pink_noise_dice_sum_core.sv
bench/tb_pink_noise_dice_sum_core.sv
